>>> sv/rbst_pkg.sv
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and constants for the ring buffer slot tracker.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int DEF_MAX_SLOTS = 1024;
  localparam int CFG_W         = 11;
  localparam int SLOT_W        = 10;
  localparam int FILL_W        = 11;

  localparam logic [CFG_W-1:0] SLOTS_RESET = CFG_W'(1024);

  localparam logic [1:0] OP_ADD       = 2'd0;
  localparam logic [1:0] OP_READ_TAIL = 2'd1;
  localparam logic [1:0] OP_READ_HEAD = 2'd2;
  localparam logic [1:0] OP_READ_NEXT = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       change_direction;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic              bad_command;
    logic [FILL_W-1:0] fill_length;
  } result_t;

endpackage

>>> sv/ring_buffer_slot_tracker.sv
// ----------------------------------------------------------------------------
// ring_buffer_slot_tracker
// Pointer manager for an overwriting ring buffer: hands out write slots and
// walks a read cursor between the oldest and newest entries.
// ----------------------------------------------------------------------------
//  channel   signals                   direction  handshake
//  command   start, busy, cmd          in         beat when start & !busy
//  result    done, result              out        one-cycle strobe, no stall
//  config    cfg_we, cfg_wdata         in         written when cfg_we
//
//  A command is taken every cycle (busy stays low); it is registered in the
//  command register, then passes through the pointer update logic into the
//  result register, where its result strobes on done.
//  Reset clears all pointers and flags and sets the slot count to 1024.
//  Results cannot be held off; a beat on done is taken as it appears.
// ----------------------------------------------------------------------------
module ring_buffer_slot_tracker #(
  parameter int MAX_SLOTS = rbst_pkg::DEF_MAX_SLOTS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  rbst_pkg::cmd_t            cmd,
  input  logic                      cfg_we,
  input  logic [rbst_pkg::CFG_W-1:0] cfg_wdata,
  output logic                      done,
  output rbst_pkg::result_t         result
);
  import rbst_pkg::*;

  localparam int PW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int NW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [NW-1:0] MAXN = NW'(MAX_SLOTS);

  logic [CFG_W-1:0] buffer_slots;
  logic             cmd_valid;
  cmd_t             cmd_q;

  logic [PW-1:0] write_slot, write_slot_next;
  logic [PW-1:0] oldest_slot, oldest_slot_next;
  logic [PW-1:0] read_cursor, read_cursor_next;
  logic          read_backward, read_backward_next;
  logic          wrapped, wrapped_next;
  logic          error_flag, error_flag_next;

  logic [NW-1:0] n_eff;
  logic [NW-1:0] last;
  logic [PW-1:0] last_p;
  logic [PW-1:0] slot;
  logic [PW-1:0] cur_fwd;
  logic          dir;
  result_t       result_next;

  // step up with wrap past the last slot
  function automatic logic [PW-1:0] step_up(input logic [PW-1:0] p,
                                            input logic [NW-1:0] lst);
    logic [NW-1:0] s;
    s = NW'(p) + NW'(1);
    return (s > lst) ? '0 : PW'(s);
  endfunction

  assign busy = 1'b0;

  always_comb begin
    n_eff = NW'(buffer_slots);
    if (buffer_slots == '0) begin
      n_eff = NW'(1);
    end else if (NW'(buffer_slots) > MAXN) begin
      n_eff = MAXN;
    end
    last   = n_eff - NW'(1);
    last_p = PW'(last);
  end

  always_comb begin
    write_slot_next    = write_slot;
    oldest_slot_next   = oldest_slot;
    read_cursor_next   = read_cursor;
    read_backward_next = read_backward;
    wrapped_next       = wrapped;
    error_flag_next    = error_flag;
    slot               = read_cursor;
    dir                = read_backward ^ cmd_q.change_direction;
    cur_fwd            = step_up(read_cursor, last);

    case (cmd_q.op)
      OP_ADD: begin
        slot = write_slot;
        write_slot_next = step_up(write_slot, last);
        if (write_slot == oldest_slot && wrapped) begin
          oldest_slot_next   = step_up(oldest_slot, last);
          read_cursor_next   = step_up(oldest_slot, last);
          read_backward_next = 1'b0;
        end
        if (NW'(write_slot) + NW'(1) > last) begin
          wrapped_next = 1'b1;
        end
        error_flag_next = 1'b0;
      end
      OP_READ_TAIL: begin
        read_backward_next = 1'b0;
        read_cursor_next   = oldest_slot;
        error_flag_next    = (write_slot == oldest_slot) && !wrapped;
        slot               = oldest_slot;
      end
      OP_READ_HEAD: begin
        read_backward_next = 1'b1;
        error_flag_next    = 1'b0;
        if (!wrapped && write_slot == oldest_slot) begin
          read_cursor_next = '0;
          error_flag_next  = 1'b1;
        end else begin
          read_cursor_next = (write_slot == '0) ? last_p : write_slot - PW'(1);
        end
        slot = read_cursor_next;
      end
      default: begin
        // read next; a set error flag freezes everything
        if (!error_flag) begin
          read_backward_next = dir;
          if (!dir) begin
            read_cursor_next = cur_fwd;
            if (cur_fwd == write_slot) begin
              read_cursor_next = (cur_fwd == '0) ? last_p : cur_fwd - PW'(1);
              error_flag_next  = 1'b1;
            end
          end else begin
            if (read_cursor == oldest_slot) begin
              error_flag_next = 1'b1;
            end else begin
              read_cursor_next = (read_cursor != '0) ? read_cursor - PW'(1) : last_p;
            end
          end
        end
        slot = read_cursor_next;
      end
    endcase

    result_next.slot_index  = SLOT_W'(slot);
    result_next.bad_command = error_flag_next;
    result_next.fill_length = wrapped_next ? FILL_W'(n_eff) : FILL_W'(write_slot_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_slots  <= SLOTS_RESET;
      cmd_valid     <= 1'b0;
      done          <= 1'b0;
      write_slot    <= '0;
      oldest_slot   <= '0;
      read_cursor   <= '0;
      read_backward <= 1'b0;
      wrapped       <= 1'b0;
      error_flag    <= 1'b0;
    end else begin
      if (cfg_we) begin
        buffer_slots <= cfg_wdata;
      end
      cmd_valid <= start && !busy;
      done      <= cmd_valid;
      if (cmd_valid) begin
        write_slot    <= write_slot_next;
        oldest_slot   <= oldest_slot_next;
        read_cursor   <= read_cursor_next;
        read_backward <= read_backward_next;
        wrapped       <= wrapped_next;
        error_flag    <= error_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
    end
    if (cmd_valid) begin
      result <= result_next;
    end
  end

endmodule

>>> sv/rbst_checker.sv
// ----------------------------------------------------------------------------
// rbst_checker
// Port-level checks for the ring buffer slot tracker, bound to the top level.
// ----------------------------------------------------------------------------
module rbst_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input rbst_pkg::cmd_t             cmd,
  input logic                       done,
  input rbst_pkg::result_t          result
);
  import rbst_pkg::*;

  // every accepted beat is followed by a result on done
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && start && !busy |=> ##1 done)
    else $error("accepted command produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done && $past(!rst) && $past(!rst, 2) |-> $past(start && !busy, 2))
    else $error("result without a command");

  // an add always clears the error
  a_add_clears: assert property (@(posedge clk) disable iff (rst)
    done && $past(!rst, 2) && $past(cmd.op == OP_ADD, 2) |-> !result.bad_command)
    else $error("add reported bad_command");

  // only an add or a new slot count changes the fill length
  a_fill_stable: assert property (@(posedge clk) disable iff (rst)
    done && $past(done) && $past(!rst, 3) && $past(cmd.op != OP_ADD, 2)
      |-> result.fill_length == $past(result.fill_length))
    else $error("fill length moved on a read");

endmodule

bind ring_buffer_slot_tracker rbst_checker u_rbst_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .done   (done),
  .result (result)
);
